@@ rtl/dlts_pkg.sv @@
// Shared types and constants of the delta-list task scheduler.
package dlts_pkg;

    localparam int ID_W     = 4;
    localparam int ID_POOL  = 16;
    localparam int CNT_W    = 5;
    localparam int HANDLE_W = 16;
    localparam int DELTA_W  = 32;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_DELETE   = 2'd1,
        OP_TICK     = 2'd2,
        OP_DISPATCH = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SLOT   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_NOT_DUE   = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_POP,
        CMD_STEP,
        CMD_INSERT,
        CMD_REMOVE,
        CMD_PUSH,
        CMD_TICK,
        CMD_LOAD_HEAD
    } t_cmd;

    typedef struct packed {
        logic no_room;
        logic ins_stop;
        logic del_hit;
        logic del_end;
        logic head_due;
        logic per_zero;
    } t_dp_status;

    typedef struct packed {
        logic    valid;
        t_status status;
        logic    show_id;
        logic    fired;
    } t_result;

endpackage

@@ rtl/dlts_ctrl.sv @@
// Controller state machine of the delta-list task scheduler.
module dlts_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  dlts_pkg::t_op       i_op,
    input  logic                i_release_id,
    input  dlts_pkg::t_dp_status i_dp,
    output dlts_pkg::t_cmd      o_cmd,
    output logic                busy,
    output dlts_pkg::t_result   o_res
);
    import dlts_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ADD, S_WALK, S_DEL, S_PUSH, S_TICK, S_DSP, S_DRM
    } t_state;

    t_state  r_state, n_state;
    logic    r_release, n_release;
    logic    r_fired, n_fired;
    t_result r_res, n_res;
    t_cmd    n_cmd;

    always_comb begin
        n_state   = r_state;
        n_release = r_release;
        n_fired   = r_fired;
        n_cmd     = CMD_NONE;
        n_res     = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd     = CMD_LOAD;
                    n_release = i_release_id;
                    n_fired   = 1'b0;
                    case (i_op)
                        OP_ADD:    n_state = S_ADD;
                        OP_DELETE: n_state = S_DEL;
                        OP_TICK:   n_state = S_TICK;
                        default:   n_state = S_DSP;
                    endcase
                end
            end
            S_ADD: begin
                if (i_dp.no_room) begin
                    n_res   = '{valid: 1'b1, status: ST_NO_SLOT, show_id: 1'b0, fired: 1'b0};
                    n_state = S_IDLE;
                end else begin
                    n_cmd   = CMD_POP;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (i_dp.ins_stop) begin
                    n_cmd   = CMD_INSERT;
                    n_res   = '{valid: 1'b1, status: ST_OK, show_id: 1'b1, fired: r_fired};
                    n_state = S_IDLE;
                end else begin
                    n_cmd = CMD_STEP;
                end
            end
            S_DEL: begin
                if (i_dp.del_hit) begin
                    n_cmd = CMD_REMOVE;
                    if (r_release) begin
                        n_state = S_PUSH;
                    end else begin
                        n_res   = '{valid: 1'b1, status: ST_OK, show_id: 1'b0, fired: 1'b0};
                        n_state = S_IDLE;
                    end
                end else if (i_dp.del_end) begin
                    n_res   = '{valid: 1'b1, status: ST_NOT_FOUND, show_id: 1'b0, fired: 1'b0};
                    n_state = S_IDLE;
                end else begin
                    n_cmd = CMD_STEP;
                end
            end
            S_PUSH: begin
                n_cmd   = CMD_PUSH;
                n_res   = '{valid: 1'b1, status: ST_OK, show_id: r_fired, fired: r_fired};
                n_state = S_IDLE;
            end
            S_TICK: begin
                n_cmd   = CMD_TICK;
                n_res   = '{valid: 1'b1, status: ST_OK, show_id: 1'b0, fired: 1'b0};
                n_state = S_IDLE;
            end
            S_DSP: begin
                if (i_dp.head_due) begin
                    n_cmd   = CMD_LOAD_HEAD;
                    n_fired = 1'b1;
                    n_state = S_DRM;
                end else begin
                    n_res   = '{valid: 1'b1, status: ST_NOT_DUE, show_id: 1'b0, fired: 1'b0};
                    n_state = S_IDLE;
                end
            end
            S_DRM: begin
                // A one-shot head frees its id; a periodic one is walked back in.
                n_cmd   = CMD_REMOVE;
                n_state = i_dp.per_zero ? S_PUSH : S_WALK;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_release <= 1'b0;
            r_fired   <= 1'b0;
            r_res     <= '0;
        end else begin
            r_state   <= n_state;
            r_release <= n_release;
            r_fired   <= n_fired;
            r_res     <= n_res;
        end
    end

    assign o_cmd = n_cmd;
    assign busy  = (r_state != S_IDLE);
    assign o_res = r_res;

endmodule

@@ rtl/dlts_dp.sv @@
// Datapath of the delta-list task scheduler: entry list, walk registers and id pool.
module dlts_dp #(
    parameter int TASK_SLOTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dlts_pkg::t_cmd                i_cmd,
    input  logic [dlts_pkg::HANDLE_W-1:0] i_task_handle,
    input  logic [dlts_pkg::DELTA_W-1:0]  i_first_delay,
    input  logic [dlts_pkg::DELTA_W-1:0]  i_repeat_period,
    input  logic [dlts_pkg::ID_W-1:0]     i_target_id,
    output dlts_pkg::t_dp_status          o_dp,
    output logic [dlts_pkg::ID_W-1:0]     o_id,
    output logic [dlts_pkg::HANDLE_W-1:0] o_handle
);
    import dlts_pkg::*;

    localparam int IW = $clog2(TASK_SLOTS);
    localparam logic [IW-1:0] LAST = IW'(TASK_SLOTS - 1);

    logic [ID_W-1:0]     r_eid  [TASK_SLOTS];
    logic [HANDLE_W-1:0] r_ehdl [TASK_SLOTS];
    logic [DELTA_W-1:0]  r_edel [TASK_SLOTS];
    logic [DELTA_W-1:0]  r_eper [TASK_SLOTS];
    logic                r_eval [TASK_SLOTS];
    logic [ID_W-1:0]     n_eid  [TASK_SLOTS];
    logic [HANDLE_W-1:0] n_ehdl [TASK_SLOTS];
    logic [DELTA_W-1:0]  n_edel [TASK_SLOTS];
    logic [DELTA_W-1:0]  n_eper [TASK_SLOTS];
    logic                n_eval [TASK_SLOTS];

    logic [ID_W-1:0]  r_fifo [ID_POOL];
    logic [ID_W-1:0]  r_head;
    logic [CNT_W-1:0] r_count;

    logic [IW-1:0]       r_idx;
    logic [DELTA_W-1:0]  r_d;
    logic [DELTA_W-1:0]  r_per;
    logic [ID_W-1:0]     r_id;
    logic [HANDLE_W-1:0] r_hdl;

    logic                cur_val, nxt_val;
    logic [DELTA_W-1:0]  cur_del, nxt_del;
    logic [ID_W-1:0]     cur_id;
    logic [IW:0]         idx_p1;

    assign cur_val = r_eval[r_idx];
    assign cur_del = r_edel[r_idx];
    assign cur_id  = r_eid[r_idx];
    assign idx_p1  = {1'b0, r_idx} + 1'b1;
    assign nxt_val = (r_idx != LAST) && r_eval[IW'(idx_p1)];
    assign nxt_del = r_edel[IW'(idx_p1)];

    assign o_dp.no_room  = r_eval[TASK_SLOTS-1] || (r_count == '0);
    assign o_dp.ins_stop = !cur_val || (r_d < cur_del);
    assign o_dp.del_hit  = cur_val && (cur_id == r_id);
    assign o_dp.del_end  = !cur_val || (r_idx == LAST);
    assign o_dp.head_due = r_eval[0] && (r_edel[0] == '0);
    assign o_dp.per_zero = (r_per == '0);
    assign o_id     = r_id;
    assign o_handle = r_hdl;

    // The whole list shifts at once; each slot looks only at its neighbors and the walk registers.
    always_comb begin
        for (int j = 0; j < TASK_SLOTS; j++) begin
            n_eid[j]  = r_eid[j];
            n_ehdl[j] = r_ehdl[j];
            n_edel[j] = r_edel[j];
            n_eper[j] = r_eper[j];
            n_eval[j] = r_eval[j];
            if (i_cmd == CMD_INSERT) begin
                if ((IW+1)'(j) == {1'b0, r_idx}) begin
                    n_eid[j]  = r_id;
                    n_ehdl[j] = r_hdl;
                    n_edel[j] = r_d;
                    n_eper[j] = r_per;
                    n_eval[j] = 1'b1;
                end else if (j > 0 && (IW+1)'(j) > {1'b0, r_idx}) begin
                    n_eid[j]  = r_eid[j-1];
                    n_ehdl[j] = r_ehdl[j-1];
                    n_edel[j] = r_edel[j-1];
                    n_eper[j] = r_eper[j-1];
                    n_eval[j] = r_eval[j-1];
                    if ((IW+1)'(j) == idx_p1 && cur_val)
                        n_edel[j] = cur_del - r_d;
                end
            end else if (i_cmd == CMD_REMOVE) begin
                if ((IW+1)'(j) >= {1'b0, r_idx}) begin
                    if (j < TASK_SLOTS - 1) begin
                        n_eid[j]  = r_eid[j+1];
                        n_ehdl[j] = r_ehdl[j+1];
                        n_edel[j] = r_edel[j+1];
                        n_eper[j] = r_eper[j+1];
                        n_eval[j] = r_eval[j+1];
                        if ((IW+1)'(j) == {1'b0, r_idx} && nxt_val)
                            n_edel[j] = nxt_del + cur_del;
                    end else begin
                        n_eid[j]  = '0;
                        n_ehdl[j] = '0;
                        n_edel[j] = '0;
                        n_eper[j] = '0;
                        n_eval[j] = 1'b0;
                    end
                end
            end else if (i_cmd == CMD_TICK && j == 0) begin
                if (r_eval[0] && r_edel[0] != '0)
                    n_edel[0] = r_edel[0] - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < TASK_SLOTS; j++) begin
                r_eid[j]  <= '0;
                r_ehdl[j] <= '0;
                r_edel[j] <= '0;
                r_eper[j] <= '0;
                r_eval[j] <= 1'b0;
            end
            for (int k = 0; k < ID_POOL; k++)
                r_fifo[k] <= ID_W'(k);
            r_head  <= '0;
            r_count <= CNT_W'(ID_POOL);
        end else begin
            for (int j = 0; j < TASK_SLOTS; j++) begin
                r_eid[j]  <= n_eid[j];
                r_ehdl[j] <= n_ehdl[j];
                r_edel[j] <= n_edel[j];
                r_eper[j] <= n_eper[j];
                r_eval[j] <= n_eval[j];
            end
            if (i_cmd == CMD_POP) begin
                r_head  <= r_head + 1'b1;
                r_count <= r_count - 1'b1;
            end else if (i_cmd == CMD_PUSH && r_count < CNT_W'(ID_POOL)) begin
                r_fifo[r_head + r_count[ID_W-1:0]] <= r_id;
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Walk registers carry no reset.
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_idx <= '0;
                r_d   <= i_first_delay;
                r_per <= i_repeat_period;
                r_hdl <= i_task_handle;
                r_id  <= i_target_id;
            end
            CMD_POP: r_id <= r_fifo[r_head];
            CMD_STEP: begin
                r_idx <= r_idx + 1'b1;
                r_d   <= r_d - cur_del;
            end
            CMD_LOAD_HEAD: begin
                r_idx <= '0;
                r_d   <= r_eper[0];
                r_per <= r_eper[0];
                r_hdl <= r_ehdl[0];
                r_id  <= r_eid[0];
            end
            CMD_REMOVE: r_idx <= '0;
            default: ;
        endcase
    end

endmodule

@@ rtl/delta_list_task_scheduler_core.sv @@
// Top level of the delta-list task scheduler.
//
// Requests enter on start with op, handle, delays, target id and release flag;
// a request is taken at an edge where start is high and busy is low.
// Each request gives one result: o_valid is high for one cycle with o_status,
// o_result_id, o_fired and o_fired_handle; the receiver cannot stall it.
// Tick and a failed add or dispatch do not walk the list; delete walks it slot by slot
// to the matching slot (and then frees the id with release), add walks it to the insert
// position, and dispatch of a periodic task walks it back in at the position its period
// gives; dispatch of a one-shot task frees its id instead.
// A new request may be taken in the cycle that shows the previous result.
// Synchronous reset empties the list and refills the id pool with 0 to 15.
module delta_list_task_scheduler_core #(
    parameter int TASK_SLOTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_op,
    input  logic [dlts_pkg::HANDLE_W-1:0] i_task_handle,
    input  logic [dlts_pkg::DELTA_W-1:0]  i_first_delay,
    input  logic [dlts_pkg::DELTA_W-1:0]  i_repeat_period,
    input  logic [dlts_pkg::ID_W-1:0]     i_target_id,
    input  logic                          i_release_id,
    output logic                          o_valid,
    output logic [1:0]                    o_status,
    output logic [dlts_pkg::ID_W-1:0]     o_result_id,
    output logic                          o_fired,
    output logic [dlts_pkg::HANDLE_W-1:0] o_fired_handle
);
    import dlts_pkg::*;

    t_cmd                cmd;
    t_dp_status          dp_st;
    t_result             res;
    logic [ID_W-1:0]     dp_id;
    logic [HANDLE_W-1:0] dp_hdl;

    dlts_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_op         (t_op'(i_op)),
        .i_release_id (i_release_id),
        .i_dp         (dp_st),
        .o_cmd        (cmd),
        .busy         (busy),
        .o_res        (res)
    );

    dlts_dp #(.TASK_SLOTS(TASK_SLOTS)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_task_handle   (i_task_handle),
        .i_first_delay   (i_first_delay),
        .i_repeat_period (i_repeat_period),
        .i_target_id     (i_target_id),
        .o_dp            (dp_st),
        .o_id            (dp_id),
        .o_handle        (dp_hdl)
    );

    assign o_valid        = res.valid;
    assign o_status       = res.status;
    assign o_result_id    = res.show_id ? dp_id : '0;
    assign o_fired        = res.fired;
    assign o_fired_handle = res.fired ? dp_hdl : '0;

endmodule
